>>> src/qpp_pkg.sv
// Shared types, constants and code tables for the quadtree path painter.
`timescale 1ns / 1ps

package qpp_pkg;

    localparam int QPP_MAX_SIDE = 64;

    localparam int CODE_W       = 14;
    localparam int ROW_IN_W     = 6;
    localparam int BITS_W       = 64;
    localparam int SIDE_LOG2_W  = 3;

    localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_RESET = 3'd6;

    // base-5 digit split: q = (x * DIV_RECIP) >> DIV_SH is exact for 14-bit x
    localparam int DIGIT_BASE = 5;
    localparam int DIV_SH     = 16;
    localparam int DIV_RECIP  = (1 << DIV_SH) / DIGIT_BASE + 1;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_PAINT = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_DIGIT = 2'd1;
    localparam logic [1:0] ST_TOO_DEEP   = 2'd2;

    // quadrant offsets, indexed by digit - 1
    localparam logic [3:0] QUAD_ROW_OFF = 4'b1100;
    localparam logic [3:0] QUAD_COL_OFF = 4'b1010;

    typedef struct packed {
        logic [1:0]          mode;
        logic [CODE_W-1:0]   code;
        logic [ROW_IN_W-1:0] row;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [BITS_W-1:0] row_bits;
    } t_out;

    typedef struct packed {
        logic done;
        logic zero_err;
        logic too_deep;
    } t_walk_flags;

    typedef struct packed {
        logic rd_en;
        logic we;
        logic clr;
    } t_mem_ctl;

endpackage

>>> src/qpp_bitmap_mem.sv
// Bitmap row memory: one write port, one registered read port, per-row valid bits.
`timescale 1ns / 1ps

module qpp_bitmap_mem #(
    parameter int MAX_SIDE = qpp_pkg::QPP_MAX_SIDE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  qpp_pkg::t_mem_ctl           i_ctl,
    input  logic [$clog2(MAX_SIDE)-1:0] i_raddr,
    input  logic [$clog2(MAX_SIDE)-1:0] i_waddr,
    input  logic [qpp_pkg::BITS_W-1:0]  i_wdata,
    output logic [qpp_pkg::BITS_W-1:0]  o_rdata
);

    logic [qpp_pkg::BITS_W-1:0] r_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0]        r_row_vld;
    logic [qpp_pkg::BITS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_row_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    // a row never written since reset or the last clear reads as blank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_ctl.clr) begin
            r_row_vld <= '0;
        end else if (i_ctl.we) begin
            r_row_vld[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/qpp_code_walk.sv
// Iterative base-5 node code walker: one digit per cycle, tracks square origin and size.
`timescale 1ns / 1ps

module qpp_code_walk #(
    parameter int MAX_SIDE = qpp_pkg::QPP_MAX_SIDE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [qpp_pkg::CODE_W-1:0]      i_code,
    input  logic [$clog2(MAX_SIDE+1)-1:0]   i_side,
    output qpp_pkg::t_walk_flags            o_flags,
    output logic [$clog2(MAX_SIDE+1)-1:0]   o_row,
    output logic [$clog2(MAX_SIDE+1)-1:0]   o_col,
    output logic [$clog2(MAX_SIDE+1)-1:0]   o_len
);

    localparam int SIDE_W = $clog2(MAX_SIDE+1);
    localparam int PROD_W = qpp_pkg::CODE_W + qpp_pkg::DIV_SH;

    logic                       r_busy;
    logic [qpp_pkg::CODE_W-1:0] r_rest;
    logic [SIDE_W-1:0]          r_len;
    logic [SIDE_W-1:0]          r_row;
    logic [SIDE_W-1:0]          r_col;
    logic                       r_zero;
    logic                       r_deep;

    logic [PROD_W-1:0]          prod;
    logic [qpp_pkg::CODE_W-1:0] quot;
    logic [qpp_pkg::CODE_W-1:0] rem;
    logic [2:0]                 digit;
    logic [1:0]                 quad;
    logic [SIDE_W-1:0]          half;

    always_comb begin
        prod  = PROD_W'(r_rest) * PROD_W'(qpp_pkg::DIV_RECIP);
        quot  = qpp_pkg::CODE_W'(prod >> qpp_pkg::DIV_SH);
        rem   = r_rest - (quot << 2) - quot;
        digit = rem[2:0];
        quad  = 2'(digit - 3'd1);
        half  = r_len >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_rest == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rest <= i_code;
            r_len  <= i_side;
            r_row  <= '0;
            r_col  <= '0;
            r_zero <= 1'b0;
            r_deep <= 1'b0;
        end else if (r_busy && (r_rest != '0)) begin
            r_rest <= quot;
            if (digit == 3'd0) begin
                r_zero <= 1'b1;
            end else begin
                // square shrinks to nothing: code is deeper than the image
                r_len <= half;
                if (half == '0) begin
                    r_deep <= 1'b1;
                end
                r_row <= r_row + (qpp_pkg::QUAD_ROW_OFF[quad] ? half : '0);
                r_col <= r_col + (qpp_pkg::QUAD_COL_OFF[quad] ? half : '0);
            end
        end
    end

    assign o_flags.done     = r_busy && (r_rest == '0);
    assign o_flags.zero_err = r_zero;
    assign o_flags.too_deep = r_deep;
    assign o_row            = r_row;
    assign o_col            = r_col;
    assign o_len            = r_len;

endmodule

>>> src/quadtree_path_painter.sv
// Top level of the quadtree path painter: request control, row painting and result register.
`timescale 1ns / 1ps

// Keeps a square black/white bitmap of up to MAX_SIDE x MAX_SIDE pixels, one
// 64-bit row per memory entry, cleared by reset. Each request clears the
// bitmap, paints one quadtree node given as a base-5 code (least significant
// digit = top-level quadrant, 1 TL, 2 TR, 3 BL, 4 BR), or reads one row.
// Every request returns exactly one result {status, row_bits}.
// Steps from acceptance until the result is loaded into the output register
// (loading waits while that register holds a result not yet taken):
//   clear / unused mode : no further steps (all rows' valid bits drop at once)
//   read row            : one synchronous memory read
//   paint               : the walker steps through the digits, then the
//                         read-modify-write of each row of the square (one
//                         row read per cycle, then the trailing write-back).
// The paint time is set by the single memory port pair: each painted row is
// read and written back once, reads of the next row overlapping the write of
// the previous one. No clearing pass is needed after reset. The block takes
// one request at a time; a finished result may wait in the output register
// while the next request is accepted. The user must write the side_log2
// register only while idle; the block itself does not enforce this.
module quadtree_path_painter #(
    parameter int MAX_SIDE = qpp_pkg::QPP_MAX_SIDE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qpp_pkg::SIDE_LOG2_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  qpp_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output qpp_pkg::t_out                   o_out_data
);

    localparam int ROW_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE+1);
    localparam int POW_W  = (1 << qpp_pkg::SIDE_LOG2_W) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_PAINT = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // span of len set bits starting at bit start
    function automatic logic [qpp_pkg::BITS_W-1:0] span_mask(
        input logic [SIDE_W-1:0] start,
        input logic [SIDE_W-1:0] len
    );
        logic [qpp_pkg::BITS_W:0] ones;
        ones = ({{qpp_pkg::BITS_W{1'b0}}, 1'b1} << len) - 1'b1;
        return ones[qpp_pkg::BITS_W-1:0] << start;
    endfunction

    logic [2:0]                      r_state;
    logic [2:0]                      n_state;
    logic [qpp_pkg::SIDE_LOG2_W-1:0] r_side_log2;
    qpp_pkg::t_out                   r_res;
    qpp_pkg::t_out                   r_out;
    logic                            r_out_valid;
    logic                            r_row_ok;
    logic [qpp_pkg::BITS_W-1:0]      r_cols;
    logic [SIDE_W-1:0]               r_rd_row;
    logic [SIDE_W-1:0]               r_left;
    logic                            r_wb_vld;
    logic [ROW_W-1:0]                r_wb_row;

    logic [POW_W-1:0]           side_pow;
    logic [SIDE_W-1:0]          side;
    logic                       in_acc;
    logic                       out_load;
    logic                       walk_start;
    qpp_pkg::t_walk_flags       walk_flags;
    logic [SIDE_W-1:0]          walk_row;
    logic [SIDE_W-1:0]          walk_col;
    logic [SIDE_W-1:0]          walk_len;
    qpp_pkg::t_mem_ctl          mem_ctl;
    logic [ROW_W-1:0]           mem_raddr;
    logic [qpp_pkg::BITS_W-1:0] mem_wdata;
    logic [qpp_pkg::BITS_W-1:0] mem_rdata;
    logic                       paint_issue;

    // image side, saturated to MAX_SIDE
    always_comb begin
        side_pow = POW_W'(1) << r_side_log2;
        if (32'(side_pow) > MAX_SIDE) begin
            side = SIDE_W'(MAX_SIDE);
        end else begin
            side = side_pow[SIDE_W-1:0];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_load    = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign walk_start  = in_acc && (i_in_data.mode == qpp_pkg::MODE_PAINT);
    assign paint_issue = (r_state == S_PAINT) && (r_left != '0);

    // memory requests: row read, paint read, write-back, clear
    always_comb begin
        mem_ctl.clr   = in_acc && (i_in_data.mode == qpp_pkg::MODE_CLEAR);
        mem_ctl.rd_en = (in_acc && (i_in_data.mode == qpp_pkg::MODE_READ)) || paint_issue;
        mem_ctl.we    = r_wb_vld;
        mem_raddr     = paint_issue ? r_rd_row[ROW_W-1:0] : i_in_data.row[ROW_W-1:0];
        mem_wdata     = mem_rdata | r_cols;
    end

    qpp_code_walk #(
        .MAX_SIDE (MAX_SIDE)
    ) u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (walk_start),
        .i_code  (i_in_data.code),
        .i_side  (side),
        .o_flags (walk_flags),
        .o_row   (walk_row),
        .o_col   (walk_col),
        .o_len   (walk_len)
    );

    qpp_bitmap_mem #(
        .MAX_SIDE (MAX_SIDE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mem_ctl),
        .i_raddr (mem_raddr),
        .i_waddr (r_wb_row),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.mode)
                        qpp_pkg::MODE_PAINT: n_state = S_WALK;
                        qpp_pkg::MODE_READ:  n_state = S_READ;
                        default:             n_state = S_FIN;
                    endcase
                end
            end
            S_WALK: begin
                if (walk_flags.done) begin
                    if (walk_flags.zero_err || walk_flags.too_deep) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_PAINT;
                    end
                end
            end
            S_PAINT: begin
                if ((r_left == '0) && !r_wb_vld) begin
                    n_state = S_FIN;
                end
            end
            S_READ: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_side_log2 <= qpp_pkg::SIDE_LOG2_RESET;
            r_out_valid <= 1'b0;
            r_wb_vld    <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
            if (i_cfg_we) begin
                r_side_log2 <= i_cfg_data;
            end
            // write-back follows each paint read in the next cycle
            r_wb_vld <= paint_issue;
            if (paint_issue) begin
                r_left <= r_left - 1'b1;
            end else if ((r_state == S_WALK) && walk_flags.done) begin
                r_left <= walk_len;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res    <= '0;
            r_row_ok <= (32'(i_in_data.row) < 32'(side));
        end
        if ((r_state == S_WALK) && walk_flags.done) begin
            if (walk_flags.zero_err) begin
                r_res.status <= qpp_pkg::ST_ZERO_DIGIT;
            end else if (walk_flags.too_deep) begin
                r_res.status <= qpp_pkg::ST_TOO_DEEP;
            end else begin
                r_res.status <= qpp_pkg::ST_OK;
            end
            r_cols   <= span_mask(walk_col, walk_len);
            r_rd_row <= walk_row;
        end
        if (paint_issue) begin
            r_rd_row <= r_rd_row + 1'b1;
            r_wb_row <= r_rd_row[ROW_W-1:0];
        end
        if (r_state == S_READ) begin
            r_res.status   <= qpp_pkg::ST_OK;
            r_res.row_bits <= r_row_ok ? (mem_rdata & span_mask('0, side)) : '0;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> tb/sv/tb_quadtree_path_painter.sv
// Self-checking testbench for the quadtree path painter.
`timescale 1ns / 1ps

module tb_quadtree_path_painter;

    localparam int HALF_PERIOD  = 4;
    localparam int CLK_PERIOD   = 2 * HALF_PERIOD;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES = 100;    // longest request is a full-square paint
    localparam int ITEMS_PER_PHASE = 165;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [qpp_pkg::SIDE_LOG2_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            o_in_ready;
    qpp_pkg::t_in                    in_data;
    logic                            o_out_valid;
    logic                            out_ready;
    qpp_pkg::t_out                   o_out_data;

    // Shadow copy of the block state, updated in request acceptance order.
    logic [qpp_pkg::BITS_W-1:0]      shadow_bitmap [0:qpp_pkg::QPP_MAX_SIDE-1];
    logic [qpp_pkg::SIDE_LOG2_W-1:0] shadow_side_log2;
    qpp_pkg::t_out                   pending_outcomes [$];

    int unsigned mismatch_count = 0;
    int unsigned burst_left = 0;
    int unsigned gap_max = 4;
    int unsigned hold_off_req = 0;

    quadtree_path_painter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Side saturates at the bitmap size (side_log2 = 7 still means 64).
    function automatic int unsigned image_side();
        int unsigned s;
        s = 1 << shadow_side_log2;
        if (s > qpp_pkg::QPP_MAX_SIDE)
            s = qpp_pkg::QPP_MAX_SIDE;
        return s;
    endfunction

    function automatic logic [qpp_pkg::BITS_W-1:0] low_mask(input int unsigned n);
        if (n >= qpp_pkg::BITS_W)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // Walks the base-5 digits, root first, and ORs the addressed square in.
    function automatic logic [1:0] paint_node(input logic [qpp_pkg::CODE_W-1:0] code);
        int unsigned rest, digit, len, r, c, i;
        logic [qpp_pkg::BITS_W-1:0] cols;
        len = image_side();
        r = 0;
        c = 0;
        // zero digit check goes first, over the whole code
        rest = code;
        while (rest > 0) begin
            digit = rest % qpp_pkg::DIGIT_BASE;
            rest = rest / qpp_pkg::DIGIT_BASE;
            if (digit == 0)
                return qpp_pkg::ST_ZERO_DIGIT;
        end
        rest = code;
        while (rest > 0) begin
            digit = rest % qpp_pkg::DIGIT_BASE;
            rest = rest / qpp_pkg::DIGIT_BASE;
            len = len / 2;
            if (len == 0)
                return qpp_pkg::ST_TOO_DEEP;
            // 1 TL, 2 TR, 3 BL, 4 BR
            if (digit >= 3)
                r += len;
            if (((digit - 1) & 1) != 0)
                c += len;
        end
        cols = low_mask(len) << c;
        for (i = r; i < r + len && i < qpp_pkg::QPP_MAX_SIDE; i++)
            shadow_bitmap[i] |= cols;
        return qpp_pkg::ST_OK;
    endfunction

    function automatic qpp_pkg::t_out apply_request(input qpp_pkg::t_in req);
        qpp_pkg::t_out res;
        int unsigned side;
        res = '0;
        case (req.mode)
            qpp_pkg::MODE_CLEAR: begin
                for (int i = 0; i < qpp_pkg::QPP_MAX_SIDE; i++)
                    shadow_bitmap[i] = '0;
            end
            qpp_pkg::MODE_PAINT: begin
                res.status = paint_node(req.code);
            end
            qpp_pkg::MODE_READ: begin
                side = image_side();
                if (req.row < side)
                    res.row_bits = shadow_bitmap[req.row] & low_mask(side);
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        qpp_pkg::t_out want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with no request outstanding: status %0d, row_bits %h",
                       o_out_data.status, o_out_data.row_bits);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_out_data.status);
                    mismatch_count++;
                end
                if (o_out_data.row_bits !== want.row_bits) begin
                    $error("row_bits: expected %h, actual %h",
                           want.row_bits, o_out_data.row_bits);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: switches at random among four stall styles; a hold-off request
    // drops ready for a counted stretch so the block backs up.
    // ------------------------------------------------------------------
    initial begin
        int unsigned hold_n;
        int unsigned cyc;
        int unsigned style;
        cyc = 0;
        style = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_req != 0) begin
                hold_n = hold_off_req;
                hold_off_req = 0;
                out_ready <= 1'b0;
                repeat (hold_n) @(posedge clk);
            end else begin
                if (cyc % 256 == 0)
                    style = $urandom_range(0, 3);
                cyc++;
                case (style)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cyc % 5 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one request; bursts of random length with random gaps between.
    task automatic send_request(input qpp_pkg::t_in req);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                in_valid <= 1'b0;
                in_data  <= qpp_pkg::t_in'($urandom());
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!o_in_ready);
        pending_outcomes.push_back(apply_request(req));
    endtask

    task automatic send_fields(input logic [1:0] mode, input int unsigned code,
                               input int unsigned row);
        qpp_pkg::t_in req;
        req.mode = mode;
        req.code = qpp_pkg::CODE_W'(code);
        req.row  = qpp_pkg::ROW_IN_W'(row);
        send_request(req);
    endtask

    // Stop offering, wait for every outstanding result, then let the block go idle.
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_side_log2(input logic [qpp_pkg::SIDE_LOG2_W-1:0] value);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        shadow_side_log2 = value;
    endtask

    // All modes; paint codes mostly well-formed with nonzero digits, plus noise.
    function automatic qpp_pkg::t_in random_request();
        qpp_pkg::t_in req;
        int unsigned pick, depth, dmax, weight, code;
        req.mode = qpp_pkg::MODE_NONE;
        req.code = qpp_pkg::CODE_W'($urandom_range(0, (1 << qpp_pkg::CODE_W) - 1));
        req.row  = qpp_pkg::ROW_IN_W'($urandom_range(0, qpp_pkg::QPP_MAX_SIDE - 1));
        pick = $urandom_range(0, 99);
        dmax = (shadow_side_log2 > 6) ? 6 : shadow_side_log2;
        if (pick < 6) begin
            req.mode = qpp_pkg::MODE_CLEAR;
        end else if (pick < 10) begin
            req.mode = qpp_pkg::MODE_NONE;
        end else if (pick < 55) begin
            req.mode = qpp_pkg::MODE_PAINT;
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
                depth = $urandom_range(0, dmax);
                if (pick >= 82 && dmax < 6)
                    depth = dmax + 1;
                code = 0;
                weight = 1;
                repeat (depth) begin
                    code += $urandom_range(1, 4) * weight;
                    weight *= qpp_pkg::DIGIT_BASE;
                end
                req.code = qpp_pkg::CODE_W'(code);
            end
        end else begin
            req.mode = qpp_pkg::MODE_READ;
            if ($urandom_range(0, 99) < 85)
                req.row = qpp_pkg::ROW_IN_W'($urandom_range(0, image_side() - 1));
        end
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_state();
        send_fields(qpp_pkg::MODE_READ, 0, 0);
        send_fields(qpp_pkg::MODE_READ, 0, 63);
    endtask

    task automatic test_modes();
        send_fields(qpp_pkg::MODE_PAINT, 0, 0);        // whole image black
        send_fields(qpp_pkg::MODE_READ, 0, 63);
        send_fields(qpp_pkg::MODE_NONE, 16383, 63);    // unused mode changes nothing
        send_fields(qpp_pkg::MODE_READ, 16383, 31);    // code ignored outside paint
        send_fields(qpp_pkg::MODE_CLEAR, 16383, 63);
        send_fields(qpp_pkg::MODE_READ, 0, 0);
    endtask

    task automatic test_quadrants();
        send_fields(qpp_pkg::MODE_PAINT, 2, 0);        // top-right 32x32
        send_fields(qpp_pkg::MODE_PAINT, 3, 0);        // bottom-left 32x32
        send_fields(qpp_pkg::MODE_READ, 0, 0);
        send_fields(qpp_pkg::MODE_PAINT, 15624, 0);    // deepest: pixel (63, 63)
        send_fields(qpp_pkg::MODE_PAINT, 16383, 0);    // largest field value has a zero digit
        send_fields(qpp_pkg::MODE_PAINT, 5, 0);        // zero root digit under a nonzero one
        send_fields(qpp_pkg::MODE_READ, 0, 63);
    endtask

    task automatic test_depth_and_side();
        set_side_log2(3'd2);                           // side 4
        send_fields(qpp_pkg::MODE_PAINT, 31, 0);       // three digits: too deep
        send_fields(qpp_pkg::MODE_PAINT, 15625, 0);    // zero digit wins over depth
        send_fields(qpp_pkg::MODE_PAINT, 6, 0);        // single pixel (0, 0)
        send_fields(qpp_pkg::MODE_READ, 0, 32);        // row past the side
        send_fields(qpp_pkg::MODE_READ, 0, 63);        // last row, also past the side
        set_side_log2(3'd0);                           // side 1
        send_fields(qpp_pkg::MODE_PAINT, 1, 0);        // any digit is too deep
        send_fields(qpp_pkg::MODE_READ, 0, 0);
        set_side_log2(3'd7);                           // saturates to 64
        send_fields(qpp_pkg::MODE_PAINT, 4, 0);
        send_fields(qpp_pkg::MODE_READ, 0, 63);
    endtask

    // Receiver holds off while the sender keeps offering back to back.
    task automatic test_backpressure();
        int unsigned saved_gap;
        settle();
        saved_gap = gap_max;
        gap_max = 0;
        hold_off_req = 400;
        repeat (12) send_request(random_request());
        gap_max = saved_gap;
        settle();
    endtask

    task automatic test_random_traffic();
        logic [qpp_pkg::SIDE_LOG2_W-1:0] phase_sides [9];
        phase_sides = '{3'd6, 3'd3, 3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4, 3'd6};
        foreach (phase_sides[p]) begin
            set_side_log2(phase_sides[p]);
            gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 8);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // sender pauses mid-phase until everything has come back
                if (n == ITEMS_PER_PHASE / 2) begin
                    in_valid <= 1'b0;
                    burst_left = 0;
                    while (pending_outcomes.size() != 0) @(posedge clk);
                end
                send_request(random_request());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        in_data  <= '0;
        shadow_side_log2 = qpp_pkg::SIDE_LOG2_RESET;
        for (int i = 0; i < qpp_pkg::QPP_MAX_SIDE; i++)
            shadow_bitmap[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_modes();
        test_quadrants();
        test_depth_and_side();
        test_backpressure();
        test_random_traffic();

        settle();
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
src/qpp_pkg.sv
src/qpp_bitmap_mem.sv
src/qpp_code_walk.sv
src/quadtree_path_painter.sv
tb/sv/tb_quadtree_path_painter.sv
